// ===== sv/assert_macros.svh =====
// Assertion macros for the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds while reset is asserted.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== sv/mndt_pkg.sv =====
// Shared types and constants of the MIDI note duration tracker.
`default_nettype none

package mndt_pkg;

    localparam int CHANNEL_W = 4;
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;
    localparam int NOW_W     = 32;
    localparam int DUR_W     = 32;

    localparam logic REQ_NOTE_OFF = 1'b0;
    localparam logic REQ_NOTE_ON  = 1'b1;

    // Port controls of the note table.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_tbl_ctrl;

endpackage

`default_nettype wire

// ===== sv/mndt_table.sv =====
// Note table memory with registered read and a clearing sweep after reset.
`default_nettype none

module mndt_table
    import mndt_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_tbl_ctrl         i_ctrl,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    output logic      [DATA_W-1:0] o_rd_data,
    output logic                   o_clearing
);

    localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(DEPTH - 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clearing;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;

    // The sweep owns the write port until every entry holds zero.
    always_comb begin
        wr_en   = r_clearing | i_ctrl.wr_en;
        wr_addr = r_clearing ? r_clr_addr : i_wr_addr;
        wr_data = r_clearing ? '0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LastAddr) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

// ===== sv/midi_note_duration_tracker.sv =====
// Top level of the MIDI note duration tracker.
`default_nettype none

// The block keeps one table entry per MIDI channel and note with an active mark,
// a start time and a velocity. A note-on with nonzero velocity marks its entry
// active and records the time and velocity; it produces no result. A note-off,
// or a note-on with velocity zero, ends an active note and produces one result
// with the end time, channel, note, stored velocity and held duration (the time
// difference wraps modulo 2^TIME_WIDTH). Events whose channel or note lies
// beyond the table are ignored. A transaction is accepted at a rising edge with
// start high and busy low. After reset the block sweeps the table clear, all
// NUM_CHANNELS * NUM_NOTES entries (2048 with the defaults); busy is high for
// that whole time and low ever after. Once the sweep is done an event can be
// accepted in every cycle: the table, with one read port and one write port,
// does one read-modify-write per event, and an event that hits the entry written
// by the event just before it takes that data from a forwarding register. A
// result appears on the output ports for exactly one cycle, marked by o_strobe,
// once its event has passed stage 1. The receiver cannot stall the block, so it
// must take every strobed result.

module midi_note_duration_tracker
    import mndt_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int NUM_NOTES    = 128,
    parameter int TIME_WIDTH   = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_req_type,
    input  wire logic [CHANNEL_W-1:0] i_channel,
    input  wire logic [NOTE_W-1:0]    i_note,
    input  wire logic [VEL_W-1:0]     i_velocity,
    input  wire logic [NOW_W-1:0]     i_now_ms,
    output logic                      o_strobe,
    output logic [NOW_W-1:0]          o_end_time_ms,
    output logic [CHANNEL_W-1:0]      o_out_channel,
    output logic [NOTE_W-1:0]         o_out_note,
    output logic [VEL_W-1:0]          o_out_velocity,
    output logic [DUR_W-1:0]          o_duration_ms
);

    localparam int Depth  = NUM_CHANNELS * NUM_NOTES;
    localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int IdxW   = CHANNEL_W + NOTE_W;
    localparam int EntryW = 1 + TIME_WIDTH + VEL_W;

    // Entry layout: active mark on top, then the start time, then the velocity.
    localparam int ActBit = EntryW - 1;

    // Stage 1 holds the event whose table read is in flight.
    logic                 r_s1_vld;
    logic                 r_s1_on;
    logic                 r_s1_inr;
    logic [AddrW-1:0]     r_s1_addr;
    logic [CHANNEL_W-1:0] r_s1_ch;
    logic [NOTE_W-1:0]    r_s1_note;
    logic [VEL_W-1:0]     r_s1_vel;
    logic [NOW_W-1:0]     r_s1_now;
    logic                 r_fwd_hit;
    logic [EntryW-1:0]    r_fwd_entry;

    logic                  accept;
    logic                  in_range;
    logic [IdxW-1:0]       idx_full;
    logic [AddrW-1:0]      rd_addr;
    logic                  clearing;
    logic [EntryW-1:0]     rd_entry;
    logic [EntryW-1:0]     entry;
    logic [EntryW-1:0]     wr_entry;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] diff;
    logic                  n_strobe;
    t_tbl_ctrl             tbl_ctrl;

    assign busy   = clearing;
    assign accept = start & ~busy;

    // Table index of the incoming event; out-of-range events pass through
    // the pipeline without writing the table.
    always_comb begin
        in_range = (IdxW'(i_channel) < IdxW'(NUM_CHANNELS))
                 & (IdxW'(i_note) < IdxW'(NUM_NOTES));
        idx_full = IdxW'(i_channel) * IdxW'(NUM_NOTES) + IdxW'(i_note);
        rd_addr  = idx_full[AddrW-1:0];
    end

    // Read-modify-write of the stage 1 entry. A note-on writes a fresh entry;
    // anything else clears the active mark, which is harmless for an entry
    // that was not active.
    always_comb begin
        entry    = r_fwd_hit ? r_fwd_entry : rd_entry;
        now_t    = TIME_WIDTH'(r_s1_now);
        wr_entry = r_s1_on ? {1'b1, now_t, r_s1_vel}
                           : {1'b0, entry[ActBit-1:0]};
        diff     = now_t - entry[VEL_W +: TIME_WIDTH];
        n_strobe = r_s1_vld & r_s1_inr & ~r_s1_on & entry[ActBit];

        tbl_ctrl.rd_en = accept;
        tbl_ctrl.wr_en = r_s1_vld & r_s1_inr;
    end

    mndt_table #(
        .DEPTH  (Depth),
        .ADDR_W (AddrW),
        .DATA_W (EntryW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (tbl_ctrl),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (r_s1_addr),
        .i_wr_data  (wr_entry),
        .o_rd_data  (rd_entry),
        .o_clearing (clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_s1_vld <= accept;
            o_strobe <= n_strobe;
        end
    end

    // The table read issued at the same edge as the stage 1 write would see
    // stale data, so the written entry is forwarded when the addresses match.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_on     <= (i_req_type == REQ_NOTE_ON) & (i_velocity != '0);
            r_s1_inr    <= in_range;
            r_s1_addr   <= rd_addr;
            r_s1_ch     <= i_channel;
            r_s1_note   <= i_note;
            r_s1_vel    <= i_velocity;
            r_s1_now    <= i_now_ms;
            r_fwd_hit   <= r_s1_vld & r_s1_inr & (r_s1_addr == rd_addr);
            r_fwd_entry <= wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_strobe) begin
            o_end_time_ms  <= r_s1_now;
            o_out_channel  <= r_s1_ch;
            o_out_note     <= r_s1_note;
            o_out_velocity <= entry[VEL_W-1:0];
            o_duration_ms  <= DUR_W'(diff);
        end
    end

endmodule

`default_nettype wire

// ===== sv/mndt_checker.sv =====
// Port-level assertions of the MIDI note duration tracker and their bind.
`default_nettype none
`include "assert_macros.svh"

module mndt_checker
    import mndt_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 i_req_type,
    input wire logic [CHANNEL_W-1:0] i_channel,
    input wire logic [NOTE_W-1:0]    i_note,
    input wire logic [VEL_W-1:0]     i_velocity,
    input wire logic [NOW_W-1:0]     i_now_ms,
    input wire logic                 o_strobe,
    input wire logic [NOW_W-1:0]     o_end_time_ms,
    input wire logic [CHANNEL_W-1:0] o_out_channel,
    input wire logic [NOTE_W-1:0]    o_out_note,
    input wire logic [VEL_W-1:0]     o_out_velocity
);

    logic                        ev_ending;
    logic [CHANNEL_W+NOTE_W-1:0] ev_key;
    logic [CHANNEL_W+NOTE_W-1:0] out_key;

    // An accepted transaction that may end a note.
    assign ev_ending = start && !busy
                    && ((i_req_type == REQ_NOTE_OFF) || (i_velocity == '0));
    assign ev_key    = {i_channel, i_note};
    assign out_key   = {o_out_channel, o_out_note};

    // Every result comes from an ending event that passed through stage 1.
    `ASSERT_CLK(a_result_from_end, i_clk, i_rst_n, o_strobe |-> $past(ev_ending, 2))

    // The result echoes the time, channel and note of that event.
    `ASSERT_CLK(a_result_time, i_clk, i_rst_n, o_strobe |-> o_end_time_ms == $past(i_now_ms, 2))
    `ASSERT_CLK(a_result_key, i_clk, i_rst_n, o_strobe |-> out_key == $past(ev_key, 2))

    // A completed note always carries the nonzero velocity of its note-on.
    `ASSERT_CLK(a_result_velocity, i_clk, i_rst_n, o_strobe |-> o_out_velocity != '0)

    // Once the clearing sweep has ended, busy never comes back.
    `ASSERT_CLK(a_busy_no_rise, i_clk, i_rst_n, !$rose(busy))

endmodule

bind midi_note_duration_tracker mndt_checker u_mndt_checker (.*);

`default_nettype wire
